@@ rtl/bcu_pkg.sv @@
// Package with widths and limits for the binomial coefficient unit.
package bcu_pkg;

  localparam int ARG_W  = 6;
  localparam int ACC_W  = 64;
  localparam int COEF_W = 57;
  localparam int STEP_W = $clog2(ACC_W);
  localparam int PROD_W = ACC_W + ARG_W;

  localparam logic [ARG_W-1:0]  N_LIMIT   = ARG_W'(60);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ACC_W - 1);

endpackage

@@ rtl/binomial_coefficient_unit_top.sv @@
// Binomial coefficient unit: C(n,k) by the multiplicative rule with a shared divider.
//
//   port          dir  width  role
//   start         in   1      request strobe, taken when busy is low
//   n_value       in   6      upper argument n
//   k_value       in   6      lower argument k
//   busy          out  1      high while a transaction is in work
//   done          out  1      result strobe, one cycle
//   coefficient   out  57     C(n,k)
//
// One transaction runs from start through one loop per factor to done; k above n
// skips the loop and gives zero. Each factor passes through a loop-count check, a
// 64x6 multiply, and radix-2 restoring division of the low 64 product bits through
// one 7-bit subtractor. Synchronous reset returns the sequencer to idle. The
// receiver cannot stall: done is high for exactly one cycle, coefficient holds until
// the next result.
module binomial_coefficient_unit_top
  import bcu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ARG_W-1:0]  n_value,
  input  logic [ARG_W-1:0]  k_value,
  output logic              busy,
  output logic              done,
  output logic [COEF_W-1:0] coefficient
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  state_t              state;
  logic [ARG_W-1:0]    n_reg;
  logic [ARG_W-1:0]    k_reg;
  logic [ARG_W-1:0]    i;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    quo;
  logic [ARG_W-1:0]    rem;
  logic [STEP_W-1:0]   step;

  logic [ARG_W-1:0]    n_sat;
  logic [ARG_W-1:0]    factor;
  logic [PROD_W-1:0]   prod;
  logic [ARG_W:0]      divisor;
  logic [ARG_W:0]      rem_shift;
  logic [ARG_W:0]      diff;
  logic                fits;

  assign n_sat     = (n_value > N_LIMIT) ? N_LIMIT : n_value;
  assign factor    = n_reg - i;
  assign prod      = {{ARG_W{1'b0}}, acc} * {{ACC_W{1'b0}}, factor};
  assign divisor   = {1'b0, i} + (ARG_W+1)'(1);
  assign rem_shift = {rem, quo[ACC_W-1]};
  assign diff      = rem_shift - divisor;
  assign fits      = (rem_shift >= divisor);
  assign busy      = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n_reg <= n_sat;
            k_reg <= k_value;
            i     <= '0;
            if (k_value > n_sat) begin
              acc   <= '0;
              state <= S_FINISH;
            end else begin
              acc   <= ACC_W'(1);
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (i == k_reg) begin
            state <= S_FINISH;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          quo   <= prod[ACC_W-1:0];
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (fits) begin
            rem <= diff[ARG_W-1:0];
            quo <= {quo[ACC_W-2:0], 1'b1};
          end else begin
            rem <= rem_shift[ARG_W-1:0];
            quo <= {quo[ACC_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            acc   <= fits ? {quo[ACC_W-2:0], 1'b1} : {quo[ACC_W-2:0], 1'b0};
            i     <= i + ARG_W'(1);
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          coefficient <= acc[COEF_W-1:0];
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_exact_div: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK && $past(state) == S_DIV |-> rem == '0)
    else $error("division left a remainder");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> i <= k_reg)
    else $error("loop index ran past k");

endmodule
